### hw/rtl/ats_pkg.sv
// Shared types, codes and keyword tables for the assembler token scanner.
// Depends on nothing; every scanner module refers to it by scoped names.
`timescale 1ns / 1ps

package ats_pkg;

  localparam int unsigned MAX_TOKEN_LEN = 64;
  localparam int unsigned KEYWORD_COUNT = 29;
  localparam int unsigned KW_MAX_LEN    = 10;
  localparam int unsigned QUEUE_DEPTH   = 3;

  localparam logic [KEYWORD_COUNT-1:0] HITS_ALL = '1;
  localparam logic [23:0]              LINE_MAX = 24'hFFFFFF;

  // Result kinds.
  localparam logic [5:0] KIND_IDENT   = 6'd0;
  localparam logic [5:0] KIND_LITERAL = 6'd1;
  localparam logic [5:0] KIND_ADDRESS = 6'd2;
  localparam logic [5:0] KIND_LABEL   = 6'd3;
  localparam logic [5:0] KIND_KEY0    = 6'd4;
  localparam logic [5:0] KIND_END     = 6'd33;
  localparam logic [5:0] KIND_ERROR   = 6'd34;

  // Byte codes the scanner reacts to.
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_WORD    = 4'b0010,
    MODE_NUM     = 4'b0100,
    MODE_COMMENT = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_flag;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [6:0]  length;
    logic [31:0] value;
    logic [23:0] line;
    logic        clipped;
    logic        last;
  } out_word_t;

  // Keyword spellings, right aligned: the first character sits in the highest used byte.
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KEYWORD_COUNT] = '{
    "SUBROUTINE", "INTEGER", "DECLARE", "AND", "OR", "ADD", "SUB", "EQ",
    "CMP", "STORE", "BRA", "BRF", "BRT", "BSR", "TEST", "FLAG", "RETURN",
    "HALT", "TAKER", "RANGE", "RANDG", "RANDL", "WAIT", "EXISTS", "USER",
    "ROUTE", "GETROUTE", "GETOBJECT", "GETLEADER"
  };

  localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
    4'd10, 4'd7, 4'd7, 4'd3, 4'd2, 4'd3, 4'd3, 4'd2, 4'd3, 4'd5, 4'd3, 4'd3,
    4'd3, 4'd3, 4'd4, 4'd4, 4'd6, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd4, 4'd6,
    4'd4, 4'd5, 4'd8, 4'd9, 4'd9
  };

  // Character of keyword k at position pos, or zero past its end.
  function automatic logic [7:0] kw_char(input int unsigned k, input logic [6:0] pos);
    logic [7:0]  c;
    int unsigned l;
    c = '0;
    l = int'(KW_LEN[k]);
    for (int unsigned j = 0; j < KW_MAX_LEN; j++) begin
      if (pos == 7'(j) && j < l) begin
        c = KW_TEXT[k][8*(l-1-j) +: 8];
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/ats_keyword_match.sv
// Parallel keyword hit vector update and final keyword lookup.
// Depends on ats_pkg for the keyword tables and result kinds.
`timescale 1ns / 1ps

module ats_keyword_match (
  input  logic [ats_pkg::KEYWORD_COUNT-1:0] hits_i,
  input  logic [6:0]                        pos_i,
  input  logic [7:0]                        upper_i,
  output logic [ats_pkg::KEYWORD_COUNT-1:0] hits_o,
  input  logic [ats_pkg::KEYWORD_COUNT-1:0] final_hits_i,
  input  logic [6:0]                        final_len_i,
  output logic [5:0]                        final_kind_o
);

  // A keyword stays a candidate while each new character equals its spelling.
  always_comb begin
    for (int unsigned k = 0; k < ats_pkg::KEYWORD_COUNT; k++) begin
      hits_o[k] = hits_i[k] && (upper_i == ats_pkg::kw_char(k, pos_i));
    end
  end

  // The lowest numbered candidate whose length is exactly the word length wins.
  always_comb begin
    final_kind_o = ats_pkg::KIND_IDENT;
    for (int k = int'(ats_pkg::KEYWORD_COUNT) - 1; k >= 0; k--) begin
      if (final_hits_i[k] && final_len_i == {3'b000, ats_pkg::KW_LEN[k]}) begin
        final_kind_o = ats_pkg::KIND_KEY0 + 6'(k);
      end
    end
  end

endmodule

### hw/rtl/assembler_token_scanner.sv
// Top level of the assembler token scanner: scan state, token building and result queue.
// Depends on ats_pkg and instantiates ats_keyword_match.
`timescale 1ns / 1ps

// The scanner takes one source byte, or an end marker, per input word and returns token
// result words. Whitespace is skipped, CR and LF each advance the line count, semicolon
// comments run to the line end, '@' is an address token, words become labels, keywords or
// identifiers, and digit runs become saturating decimal literals; any other byte gives an
// error word. A word or literal is reported when the byte after it arrives, and that byte
// is then scanned in the same cycle, so one input word yields zero, one or two result
// words, the final one flagged by last. Timing: an input word is taken every cycle while
// the three-entry result queue holds at most one word; in_ready depends only on that
// queue fill. An input word that yields two results can therefore hold back the next one,
// while the queue drains at one result per cycle whenever out_ready is high. Results
// leave in order from the head of the queue, which is the out_data register itself.

module assembler_token_scanner (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ats_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ats_pkg::out_word_t out_data
);

  // Scan state.
  ats_pkg::scan_mode_t               mode_r, mode_nxt;
  logic [ats_pkg::KEYWORD_COUNT-1:0] hits_r, hits_nxt;
  logic [6:0]                        len_r, len_nxt;
  logic                              colon_r, colon_nxt;
  logic [31:0]                       lit_r, lit_nxt;
  logic [23:0]                       line_r, line_nxt;
  logic                              sat_r, sat_nxt;

  // Result queue; entry 0 is the word on out_data.
  ats_pkg::out_word_t q_r [ats_pkg::QUEUE_DEPTH];
  ats_pkg::out_word_t q_nxt [ats_pkg::QUEUE_DEPTH];
  logic [1:0]         count_r, count_nxt;

  logic accept, pop;
  assign in_ready  = (count_r < 2'd2);
  assign accept    = in_valid && in_ready;
  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = q_r[0];

  // Byte classes.
  logic [7:0] ch, upper;
  logic is_letter, is_digit, is_nl, is_ws, word_cont;
  assign ch        = in_data.char_byte;
  assign is_letter = (ch >= ats_pkg::CH_UA && ch <= ats_pkg::CH_UZ) ||
                     (ch >= ats_pkg::CH_LA && ch <= ats_pkg::CH_LZ);
  assign is_digit  = (ch >= ats_pkg::CH_ZERO && ch <= ats_pkg::CH_NINE);
  assign is_nl     = (ch == ats_pkg::CH_LF) || (ch == ats_pkg::CH_CR);
  assign is_ws     = (ch == ats_pkg::CH_TAB) || (ch == ats_pkg::CH_VT) ||
                     (ch == ats_pkg::CH_FF) || (ch == ats_pkg::CH_SPACE);
  assign word_cont = is_letter || is_digit || (ch == ats_pkg::CH_COLON) ||
                     (ch == ats_pkg::CH_UNDER) || (ch == ats_pkg::CH_AMP);
  assign upper     = (ch >= ats_pkg::CH_LA && ch <= ats_pkg::CH_LZ) ? (ch - ats_pkg::CASE_BIT)
                                                                    : ch;

  logic in_word, in_num, in_comment;
  assign in_word    = (mode_r == ats_pkg::MODE_WORD);
  assign in_num     = (mode_r == ats_pkg::MODE_NUM);
  assign in_comment = (mode_r == ats_pkg::MODE_COMMENT);

  // Keyword matching. A letter seen outside a word starts a fresh hit vector at position 0.
  logic [ats_pkg::KEYWORD_COUNT-1:0] kw_hits_in, kw_hits_out;
  logic [6:0]                        kw_pos;
  logic [5:0]                        word_kind;
  assign kw_hits_in = in_word ? hits_r : ats_pkg::HITS_ALL;
  assign kw_pos     = in_word ? len_r : 7'd0;

  ats_keyword_match u_kw (
    .hits_i       (kw_hits_in),
    .pos_i        (kw_pos),
    .upper_i      (upper),
    .hits_o       (kw_hits_out),
    .final_hits_i (hits_r),
    .final_len_i  (len_r),
    .final_kind_o (word_kind)
  );

  // Literal step: value times ten plus the digit, checked against 32 bits.
  logic [35:0] lit_step;
  assign lit_step = {1'b0, lit_r, 3'b000} + {3'b000, lit_r, 1'b0} + {28'd0, ch - ats_pkg::CH_ZERO};

  // The word or literal in progress, as it would be reported now.
  ats_pkg::out_word_t fin_res, scan_res, res0, res1;
  always_comb begin
    fin_res         = '0;
    fin_res.line    = line_r;
    fin_res.clipped = sat_r;
    if (in_word) begin
      if (colon_r) begin
        fin_res.kind   = ats_pkg::KIND_LABEL;
        fin_res.length = sat_r ? 7'(ats_pkg::MAX_TOKEN_LEN) : (len_r - 7'd1);
      end else begin
        // An overlong word never matches a keyword.
        fin_res.kind   = sat_r ? ats_pkg::KIND_IDENT : word_kind;
        fin_res.length = len_r;
      end
    end else begin
      fin_res.kind   = ats_pkg::KIND_LITERAL;
      fin_res.length = len_r;
      fin_res.value  = lit_r;
    end
  end

  // Scan step for the accepted word.
  logic emit_fin, emit_scan;
  always_comb begin
    mode_nxt  = mode_r;
    hits_nxt  = hits_r;
    len_nxt   = len_r;
    colon_nxt = colon_r;
    lit_nxt   = lit_r;
    line_nxt  = line_r;
    sat_nxt   = sat_r;
    emit_fin  = 1'b0;
    emit_scan = 1'b0;
    scan_res  = '0;
    scan_res.line = line_r;

    if (accept) begin
      // A word or literal ends on end of input or on a byte that cannot extend it.
      if ((in_word && (in_data.end_flag || !word_cont)) ||
          (in_num && (in_data.end_flag || !is_digit))) begin
        emit_fin  = 1'b1;
        mode_nxt  = ats_pkg::MODE_IDLE;
        hits_nxt  = ats_pkg::HITS_ALL;
        len_nxt   = '0;
        colon_nxt = 1'b0;
        lit_nxt   = '0;
        sat_nxt   = 1'b0;
      end

      if (in_data.end_flag) begin
        // End inside a comment simply closes the comment.
        mode_nxt      = ats_pkg::MODE_IDLE;
        emit_scan     = 1'b1;
        scan_res.kind = ats_pkg::KIND_END;
      end else if (in_word && word_cont) begin
        hits_nxt  = kw_hits_out;
        colon_nxt = (ch == ats_pkg::CH_COLON);
        if (len_r < 7'(ats_pkg::MAX_TOKEN_LEN)) begin
          len_nxt = len_r + 7'd1;
        end else begin
          sat_nxt = 1'b1;
        end
      end else if (in_num && is_digit) begin
        if (lit_step[35:32] != 4'd0) begin
          lit_nxt = '1;
          sat_nxt = 1'b1;
        end else begin
          lit_nxt = lit_step[31:0];
        end
        if (len_r < 7'(ats_pkg::MAX_TOKEN_LEN)) begin
          len_nxt = len_r + 7'd1;
        end else begin
          sat_nxt = 1'b1;
        end
      end else if (in_comment && !is_nl) begin
        // Comment text is dropped.
      end else begin
        // The byte is scanned from the idle state; token fields are already clear here.
        if (is_nl) begin
          mode_nxt = ats_pkg::MODE_IDLE;
          if (line_r < ats_pkg::LINE_MAX) begin
            line_nxt = line_r + 24'd1;
          end
        end else if (is_ws) begin
          mode_nxt = ats_pkg::MODE_IDLE;
        end else if (is_letter) begin
          mode_nxt  = ats_pkg::MODE_WORD;
          hits_nxt  = kw_hits_out;
          len_nxt   = 7'd1;
          colon_nxt = 1'b0;
          lit_nxt   = '0;
          sat_nxt   = 1'b0;
        end else if (is_digit) begin
          mode_nxt  = ats_pkg::MODE_NUM;
          hits_nxt  = ats_pkg::HITS_ALL;
          len_nxt   = 7'd1;
          colon_nxt = 1'b0;
          lit_nxt   = {24'd0, ch - ats_pkg::CH_ZERO};
          sat_nxt   = 1'b0;
        end else if (ch == ats_pkg::CH_SEMI) begin
          mode_nxt = ats_pkg::MODE_COMMENT;
        end else if (ch == ats_pkg::CH_AT) begin
          emit_scan       = 1'b1;
          scan_res.kind   = ats_pkg::KIND_ADDRESS;
          scan_res.length = 7'd1;
        end else begin
          emit_scan       = 1'b1;
          scan_res.kind   = ats_pkg::KIND_ERROR;
          scan_res.length = 7'd1;
          scan_res.value  = {24'd0, ch};
        end
      end
    end
  end

  // Order the results of this word and mark the final one.
  logic [1:0] n_res;
  always_comb begin
    res0 = emit_fin ? fin_res : scan_res;
    res1 = scan_res;
    n_res = {1'b0, emit_fin} + {1'b0, emit_scan};
    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;
  end

  // Queue update: pop shifts toward the head, new results land behind what remains.
  logic [1:0] base;
  always_comb begin
    q_nxt = q_r;
    base  = count_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
      base     = count_r - 2'd1;
    end
    for (int unsigned i = 0; i < ats_pkg::QUEUE_DEPTH; i++) begin
      if (n_res != 2'd0 && 2'(i) == base) begin
        q_nxt[i] = res0;
      end
      if (n_res == 2'd2 && 2'(i) == base + 2'd1) begin
        q_nxt[i] = res1;
      end
    end
    count_nxt = base + n_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ats_pkg::MODE_IDLE;
      hits_r  <= ats_pkg::HITS_ALL;
      len_r   <= '0;
      colon_r <= 1'b0;
      lit_r   <= '0;
      line_r  <= '0;
      sat_r   <= 1'b0;
      count_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      hits_r  <= hits_nxt;
      len_r   <= len_nxt;
      colon_r <= colon_nxt;
      lit_r   <= lit_nxt;
      line_r  <= line_nxt;
      sat_r   <= sat_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

`ifndef ASSERT_OFF
  // The queue never holds more words than it has entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(ats_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // In the idle state all token fields sit at their cleared values.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == ats_pkg::MODE_IDLE) |->
      (len_r == 7'd0 && hits_r == ats_pkg::HITS_ALL && !colon_r && !sat_r && lit_r == 32'd0))
    else $error("token state not cleared in idle");

  // In a word the saturation mark can only come from the length limit.
  a_word_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == ats_pkg::MODE_WORD && sat_r) |-> (len_r == 7'(ats_pkg::MAX_TOKEN_LEN)))
    else $error("word saturated below length limit");

  // The line count only ever steps up by one.
  a_line_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && line_r != $past(line_r)) |-> (line_r == $past(line_r) + 24'd1))
    else $error("line count jumped");
`endif

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the assembler token scanner: directed and random byte streams.
// Depends on ats_pkg for the word types and codes and on the assembler_token_scanner RTL.
`timescale 1ns / 1ps

// The bench streams source bytes and end markers into the scanner through a valid/ready
// driver and checks every result word against a scanner predictor kept in this module.
// The stream starts with a short directed run (extreme bytes, lone symbols, ends inside
// a comment, a literal and a word, repeated ends, every kind of whitespace, a label).
// After that it is built from random token fragments: keywords in mixed case, cut short
// or run on, identifiers, labels, literals up to and past 32-bit saturation, words and
// digit runs around the length limit, comments with random bodies, addresses, error
// bytes and plain noise. Both sides idle at random, with a steady window where neither
// does. The receiver stalls once for a long stretch so the result queue fills and the
// scanner pushes back, and the sender twice waits until every expected word is back.

module tb;
  import ats_pkg::*;

  localparam int RANDOM_WORDS      = 1850;
  localparam int IDLE_PERCENT      = 31;
  localparam int STEADY_FROM       = 1000;
  localparam int STEADY_TO         = 1300;
  localparam int LONG_STALL_AT     = 500;
  localparam int LONG_STALL_CYCLES = 80;
  localparam int DRAIN_CYCLES      = 20;
  localparam int CYCLE_LIMIT       = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  assembler_token_scanner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be offered, and the result words the predictor still owes.
  in_word_t  pending_words [$];
  out_word_t expected_tokens [$];

  // Counters that cross processes, the mismatch count apart, are only written with nonblocking
  // assignments, so every process sees the same pre-edge values at a clock edge.
  int words_accepted  = 0;
  int tokens_expected = 0;
  int tokens_seen     = 0;
  int mismatches      = 0;
  int cycle_count     = 0;
  int stimulus_words  = 0;
  int total_words     = 0;
  int pause_marks [2] = '{-1, -1};
  int stall_left      = 0;
  bit stall_done      = 1'b0;

  string keyword_list [KEYWORD_COUNT] = '{
    "SUBROUTINE", "INTEGER", "DECLARE", "AND", "OR", "ADD", "SUB", "EQ",
    "CMP", "STORE", "BRA", "BRF", "BRT", "BSR", "TEST", "FLAG", "RETURN",
    "HALT", "TAKER", "RANGE", "RANDG", "RANDL", "WAIT", "EXISTS", "USER",
    "ROUTE", "GETROUTE", "GETOBJECT", "GETLEADER"
  };

  // ---------------------------------------------------------------------------------------
  // Scanner predictor. This mirrors the scanner's own state, advanced once per accepted word.
  // ---------------------------------------------------------------------------------------
  scan_mode_t           p_mode  = MODE_IDLE;
  bit [KEYWORD_COUNT-1:0] p_hits = '1;
  int                   p_len   = 0;
  bit                   p_colon = 1'b0;
  logic [31:0]          p_value = '0;
  logic [23:0]          p_line  = '0;
  bit                   p_sat   = 1'b0;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void push_token(logic [5:0] kind, int len, logic [31:0] val, bit clip);
    out_word_t t;
    t.kind    = kind;
    t.length  = 7'(len);
    t.value   = val;
    t.line    = p_line;
    t.clipped = clip;
    t.last    = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  function automatic void reset_token();
    p_mode  = MODE_IDLE;
    p_hits  = '1;
    p_len   = 0;
    p_colon = 1'b0;
    p_value = '0;
    p_sat   = 1'b0;
  endfunction

  // Characters past the length limit are not counted, but they mark the token as clipped.
  function automatic void count_token_char();
    if (p_len < MAX_TOKEN_LEN) begin
      p_len++;
    end else begin
      p_sat = 1'b1;
    end
  endfunction

  // Each keyword stays a candidate while every character so far matches it, ignoring case.
  function automatic void extend_word(logic [7:0] c);
    logic [7:0] up;
    up = (c >= CH_LA && c <= CH_LZ) ? c - CASE_BIT : c;
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      if (p_hits[k] && (p_len >= keyword_list[k].len() || up != 8'(keyword_list[k][p_len]))) begin
        p_hits[k] = 1'b0;
      end
    end
    p_colon = (c == CH_COLON);
    count_token_char();
  endfunction

  // Reports the word or literal being built, if any, and returns to idle.
  function automatic void close_token();
    logic [5:0] kind;
    bit         found;
    if (p_mode == MODE_WORD) begin
      if (p_colon) begin
        push_token(KIND_LABEL, p_sat ? MAX_TOKEN_LEN : p_len - 1, '0, p_sat);
      end else begin
        kind  = KIND_IDENT;
        found = 1'b0;
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
          if (!found && !p_sat && p_hits[k] && p_len == keyword_list[k].len()) begin
            kind  = KIND_KEY0 + 6'(k);
            found = 1'b1;
          end
        end
        push_token(kind, p_len, '0, p_sat);
      end
    end else if (p_mode == MODE_NUM) begin
      push_token(KIND_LITERAL, p_len, p_value, p_sat);
    end
    reset_token();
  endfunction

  function automatic void idle_byte(logic [7:0] c);
    if (c == CH_LF || c == CH_CR) begin
      if (p_line != LINE_MAX) p_line++;
    end else if (c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_SPACE) begin
      // Whitespace only separates tokens.
    end else if (is_letter(c)) begin
      reset_token();
      p_mode = MODE_WORD;
      extend_word(c);
    end else if (is_digit(c)) begin
      reset_token();
      p_mode  = MODE_NUM;
      p_value = 32'(c - CH_ZERO);
      p_len   = 1;
    end else if (c == CH_SEMI) begin
      p_mode = MODE_COMMENT;
    end else if (c == CH_AT) begin
      push_token(KIND_ADDRESS, 1, '0, 1'b0);
    end else begin
      push_token(KIND_ERROR, 1, 32'(c), 1'b0);
    end
  endfunction

  // Advances the predictor by one accepted word and returns how many result words it owes.
  function automatic int predict_tokens(in_word_t w);
    int          owed_before;
    logic [7:0]  c;
    logic [63:0] grown;
    out_word_t   t;
    owed_before = expected_tokens.size();
    c = w.char_byte;
    if (w.end_flag) begin
      close_token();
      push_token(KIND_END, 0, '0, 1'b0);
    end else begin
      case (p_mode)
        MODE_WORD: begin
          if (is_letter(c) || is_digit(c) || c == CH_COLON || c == CH_UNDER || c == CH_AMP) begin
            extend_word(c);
          end else begin
            close_token();
            idle_byte(c);
          end
        end
        MODE_NUM: begin
          if (is_digit(c)) begin
            grown = 64'(p_value) * 64'd10 + 64'(c - CH_ZERO);
            if (grown > 64'hFFFF_FFFF) begin
              grown = 64'hFFFF_FFFF;
              p_sat = 1'b1;
            end
            p_value = grown[31:0];
            count_token_char();
          end else begin
            close_token();
            idle_byte(c);
          end
        end
        MODE_COMMENT: begin
          // The comment ends at CR or LF, and that byte still counts a line.
          if (c == CH_LF || c == CH_CR) begin
            p_mode = MODE_IDLE;
            idle_byte(c);
          end
        end
        default: idle_byte(c);
      endcase
    end
    if (expected_tokens.size() > owed_before) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
    return expected_tokens.size() - owed_before;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stream building.
  // ---------------------------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] b);
    in_word_t w;
    w.char_byte = b;
    w.end_flag  = 1'b0;
    pending_words.push_back(w);
    stimulus_words++;
  endfunction

  // The byte carried with an end marker is random, since the scanner must ignore it.
  function automatic void add_end();
    in_word_t w;
    w.char_byte = 8'($urandom_range(255));
    w.end_flag  = 1'b1;
    pending_words.push_back(w);
    stimulus_words++;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(8'(s[i]));
  endfunction

  function automatic logic [7:0] random_letter();
    logic [7:0] c;
    c = CH_UA + 8'($urandom_range(25));
    if ($urandom_range(1) == 1) c = c | CASE_BIT;
    return c;
  endfunction

  function automatic logic [7:0] random_word_char();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return random_letter();
      5, 6, 7:       return CH_ZERO + 8'($urandom_range(9));
      8:             return ($urandom_range(1) == 1) ? CH_UNDER : CH_AMP;
      default:       return ($urandom_range(3) == 0) ? CH_COLON : random_letter();
    endcase
  endfunction

  function automatic logic [7:0] random_space();
    case ($urandom_range(5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_VT;
      3:       return CH_FF;
      4:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Bytes that can never start a token: control codes, the high half and stray symbols.
  function automatic logic [7:0] random_error_byte();
    case ($urandom_range(4))
      0:       return 8'($urandom_range(8));
      1:       return 8'($urandom_range(31, 14));
      2:       return 8'($urandom_range(255, 127));
      3:       return 8'($urandom_range(47, 33));
      default: begin
        case ($urandom_range(3))
          0:       return CH_COLON;
          1:       return CH_UNDER;
          2:       return CH_AMP;
          default: return 8'($urandom_range(126, 123));
        endcase
      end
    endcase
  endfunction

  // Appends one random token fragment; words and literals usually get a separator after it.
  task automatic add_fragment();
    int         pick;
    int         n;
    int         variant;
    string      kw;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 22) begin
      // A keyword in mixed case, now and then one letter short or run on by one character.
      kw = keyword_list[$urandom_range(KEYWORD_COUNT - 1)];
      n = kw.len();
      variant = $urandom_range(9);
      if (variant == 0) n = n - 1;
      for (int i = 0; i < n; i++) begin
        add_byte(8'(kw[i]) | (($urandom_range(1) == 1) ? CASE_BIT : 8'h00));
      end
      if (variant == 1) add_byte(random_word_char());
    end else if (pick < 42) begin
      // Identifier, or a label when it gets a closing colon.
      n = $urandom_range(12, 1);
      add_byte(random_letter());
      for (int i = 1; i < n; i++) add_byte(random_word_char());
      if (pick >= 34) add_byte(CH_COLON);
    end else if (pick < 56) begin
      n = $urandom_range(10, 1);
      for (int i = 0; i < n; i++) add_byte(CH_ZERO + 8'($urandom_range(9)));
    end else if (pick < 62) begin
      // A comment with a random body, closed by a line break or an end marker.
      add_byte(CH_SEMI);
      n = $urandom_range(12);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(255));
        if (b == CH_CR || b == CH_LF) b = CH_SPACE;
        add_byte(b);
      end
      if ($urandom_range(4) == 0) begin
        add_end();
      end else begin
        add_byte(($urandom_range(1) == 1) ? CH_CR : CH_LF);
      end
    end else if (pick < 68) begin
      add_byte(CH_AT);
    end else if (pick < 74) begin
      add_byte(random_error_byte());
    end else if (pick < 80) begin
      add_byte(8'($urandom_range(255)));
    end else if (pick < 84) begin
      add_end();
    end else if (pick < 87) begin
      // Words around the length limit, half of them labels.
      n = $urandom_range(67, 62);
      add_byte(random_letter());
      for (int i = 1; i < n; i++) add_byte(random_word_char());
      if ($urandom_range(1) == 1) add_byte(CH_COLON);
    end else if (pick < 90) begin
      // Literals at and past the 32-bit limit, and digit runs around the length limit.
      case ($urandom_range(3))
        0: add_text("4294967295");
        1: add_text("4294967296");
        2: begin
          n = $urandom_range(68, 60);
          for (int i = 0; i < n; i++) add_byte(CH_ZERO);
        end
        default: begin
          n = $urandom_range(70, 11);
          for (int i = 0; i < n; i++) add_byte(CH_ZERO + 8'($urandom_range(9)));
        end
      endcase
    end else begin
      add_byte(random_space());
    end
    // Words and literals mostly get a separator; without one they end on whatever follows.
    if ((pick < 56 || (pick >= 84 && pick < 90)) && $urandom_range(3) != 0) begin
      add_byte(random_space());
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence: build the stream, release reset, wait for the last result, report.
  // ---------------------------------------------------------------------------------------
  initial begin
    // Extreme bytes, a lone address mark and the lone symbols that cannot start a token.
    add_byte(CH_AT);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_COLON);
    add_byte(CH_UNDER);
    add_byte(CH_AMP);
    // End inside a comment, then inside a literal, then inside a keyword, then again.
    add_text(";!");
    add_end();
    add_text("7");
    add_end();
    add_text("oR");
    add_end();
    add_end();
    // Scanning resumes after an end: line breaks and every whitespace byte, then a label.
    add_byte(CH_CR);
    add_byte(CH_LF);
    add_byte(CH_TAB);
    add_byte(CH_VT);
    add_byte(CH_FF);
    add_byte(CH_SPACE);
    add_text("a: ");
    // The sender waits for every result after the directed run and once more later on.
    pause_marks[0] = pending_words.size();
    pause_marks[1] = pending_words.size() + 900;
    stimulus_words = 0;
    while (stimulus_words < RANDOM_WORDS) add_fragment();
    total_words = pending_words.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (words_accepted != total_words) @(posedge clk);
    while (tokens_seen != tokens_expected) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit steady_window();
    return words_accepted >= STEADY_FROM && words_accepted < STEADY_TO;
  endfunction

  // Sender. A word is predicted when it is accepted; the next one is offered only once the
  // current one is gone, so valid and the payload hold steady while the scanner stalls.
  always @(posedge clk) begin : driver
    int  owed;
    int  done;
    int  owed_total;
    bit  paused;
    owed = 0;
    done = words_accepted;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        owed = predict_tokens(in_data);
        done = words_accepted + 1;
        tokens_expected <= tokens_expected + owed;
        words_accepted  <= words_accepted + 1;
      end
      owed_total = tokens_expected + owed;
      paused = (done == pause_marks[0] || done == pause_marks[1]) && tokens_seen != owed_total;
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && !paused &&
            (steady_window() || $urandom_range(99) >= IDLE_PERCENT)) begin
          in_valid <= 1'b1;
          in_data  <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with one long hold-off while the sender keeps offering words.
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!stall_done && words_accepted >= LONG_STALL_AT) begin
      stall_done <= 1'b1;
      stall_left <= LONG_STALL_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= steady_window() || $urandom_range(99) >= IDLE_PERCENT;
    end
  end

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: result %0d %s: expected %0d, actual %0d", $time, tokens_seen, name,
               want, got);
      mismatches++;
    end
  endfunction

  // Monitor: every accepted result word is checked against the oldest expectation.
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      tokens_seen <= tokens_seen + 1;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        compare_field("kind", 32'(want.kind), 32'(out_data.kind));
        compare_field("length", 32'(want.length), 32'(out_data.length));
        compare_field("value", want.value, out_data.value);
        compare_field("line", 32'(want.line), 32'(out_data.line));
        compare_field("clipped", 32'(want.clipped), 32'(out_data.clipped));
        compare_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

endmodule
